>>> rtl/ppg_filter_and_heart_rate_unit_assert.svh
// assertion macros for the ppg filter and heart rate unit
`ifndef PPG_FILTER_AND_HEART_RATE_UNIT_ASSERT_SVH
`define PPG_FILTER_AND_HEART_RATE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define PPGHR_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");
`define PPGHR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define PPGHR_ASSERT_ALWAYS(lbl, clk, rst, cond)
`define PPGHR_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> rtl/ppghr_pkg.sv
// shared constants, types and helpers of the ppg filter and heart rate unit
package ppghr_pkg;

   localparam int WINDOW_DEF     = 480;
   localparam int RATE_SCALE_DEF = 6000;

   localparam int SAMP_W   = 18;
   localparam int COEF_W   = 23;
   localparam int ACC_W    = 44;
   localparam int CLIP_W   = 48;

   localparam logic signed [CLIP_W-1:0] Q_ONE = 48'sd65536;
   localparam logic signed [33:0] OFFSET_04 = 34'sd26214;
   localparam logic [15:0] BPM_MAX = 16'd65280;

   localparam logic [15:0] DC_ALPHA_RST       = 16'd62259;
   localparam logic [16:0] BEAT_THRESHOLD_RST = 17'd45875;
   localparam logic [16:0] BPM_SMOOTHING_RST  = 17'd655;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DC_ALPHA       = 2'd0,
      CSR_BEAT_THRESHOLD = 2'd1,
      CSR_BPM_SMOOTHING  = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      F_IDLE, F_MULT, F_SUM, F_Y, F_MAC, F_PUSH
   } front_state_type;

   typedef enum logic [3:0] {
      B_CLEAR, B_IDLE, B_WALK, B_DIVSET, B_DIV, B_SAT, B_BL1, B_BL2, B_OUT
   } back_state_type;

   typedef struct packed {
      logic clearing;
      logic div_start;
      logic den_nonzero;
   } back_status_type;

   // low-pass taps in q20; feedback taps are stored negated
   function automatic logic signed [COEF_W-1:0] mac_coef(input logic [2:0] k);
      logic signed [COEF_W-1:0] c;
      unique case (k)
         3'd0:    c = 23'sd7351;
         3'd1:    c = 23'sd2523;
         3'd2:    c = 23'sd2523;
         3'd3:    c = 23'sd7351;
         3'd4:    c = 23'sd2666552;
         3'd5:    c = -23'sd2347159;
         3'd6:    c = 23'sd709434;
         default: c = '0;
      endcase
      return c;
   endfunction

   function automatic logic signed [SAMP_W-1:0] clip_one(input logic signed [CLIP_W-1:0] v);
      logic signed [CLIP_W-1:0] r;
      if (v > Q_ONE) r = Q_ONE;
      else if (v < -Q_ONE) r = -Q_ONE;
      else r = v;
      return r[SAMP_W-1:0];
   endfunction

endpackage

>>> rtl/ppghr_ifs.sv
// request and response channel interfaces
interface ppghr_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] raw_ir;
   modport source (output valid, output raw_ir, input ready);
   modport sink (input valid, input raw_ir, output ready);
endinterface

interface ppghr_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [17:0] filtered_sample;
   logic [8:0]         beat_count;
   logic [15:0]        bpm_smoothed;
   logic [7:0]         bpm_whole;
   modport source (output valid, output filtered_sample, output beat_count,
                   output bpm_smoothed, output bpm_whole, input ready);
   modport sink (input valid, input filtered_sample, input beat_count,
                 input bpm_smoothed, input bpm_whole, output ready);
endinterface

>>> rtl/ppghr_front.sv
// front end: dc removal; elliptic low-pass taps share a multiplier
module ppghr_front (
   input  logic        clock,
   input  logic        reset,
   input  logic [15:0] dc_alpha,
   input  logic        hold,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic [15:0] in_raw_ir,
   output logic        q_valid,
   input  logic        q_ready,
   output logic signed [ppghr_pkg::SAMP_W-1:0] q_data
);
   localparam int SW = ppghr_pkg::SAMP_W;
   localparam int AW = ppghr_pkg::ACC_W;

   ppghr_pkg::front_state_type state_ff, state_in;

   logic signed [SW-1:0] x_ff, y_ff, filt;
   logic signed [40:0]   prod_ff;
   logic signed [23:0]   m_ff, dc_ff, m_sat;
   logic signed [SW-1:0] in_d_ff [3];
   logic signed [SW-1:0] out_d_ff [3];
   logic signed [AW-1:0] acc_ff, acc_in, acc_rnd;
   logic [2:0]           k_ff;
   logic signed [25:0]   m_sum;
   logic signed [24:0]   diff;
   logic signed [33:0]   y_raw;
   logic signed [SW-1:0] mac_op;
   logic signed [40:0]   mac_prod;
   logic                 accept;

   assign accept   = in_valid && in_ready;
   assign in_ready = (state_ff == ppghr_pkg::F_IDLE) && !hold;
   assign q_valid  = (state_ff == ppghr_pkg::F_PUSH);

   always_comb begin
      m_sum = 26'(x_ff) + 26'((prod_ff + 41'sd32768) >>> 16);
      if (m_sum > 26'sd8388607) m_sat = 24'sd8388607;
      else if (m_sum < -26'sd8388608) m_sat = -24'sd8388608;
      else m_sat = m_sum[23:0];
      diff  = 25'(m_ff) - 25'(dc_ff);
      y_raw = -(34'(diff) * 34'sd120) - ppghr_pkg::OFFSET_04;
      unique case (k_ff)
         3'd0:    mac_op = y_ff;
         3'd1:    mac_op = in_d_ff[0];
         3'd2:    mac_op = in_d_ff[1];
         3'd3:    mac_op = in_d_ff[2];
         3'd4:    mac_op = out_d_ff[0];
         3'd5:    mac_op = out_d_ff[1];
         default: mac_op = out_d_ff[2];
      endcase
      mac_prod = 41'(ppghr_pkg::mac_coef(k_ff)) * 41'(mac_op);
      acc_in   = acc_ff + AW'(mac_prod);
      acc_rnd  = (acc_ff + AW'(45'sd524288)) >>> 20;
      filt     = ppghr_pkg::clip_one(ppghr_pkg::CLIP_W'(acc_rnd));
      q_data   = filt;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ppghr_pkg::F_IDLE: if (accept) state_in = ppghr_pkg::F_MULT;
         ppghr_pkg::F_MULT: state_in = ppghr_pkg::F_SUM;
         ppghr_pkg::F_SUM:  state_in = ppghr_pkg::F_Y;
         ppghr_pkg::F_Y:    state_in = ppghr_pkg::F_MAC;
         ppghr_pkg::F_MAC:  if (k_ff == 3'd6) state_in = ppghr_pkg::F_PUSH;
         ppghr_pkg::F_PUSH: if (q_ready) state_in = ppghr_pkg::F_IDLE;
         default:           state_in = ppghr_pkg::F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ppghr_pkg::F_IDLE;
      else state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dc_ff <= '0;
         for (int i = 0; i < 3; i++) begin
            in_d_ff[i]  <= '0;
            out_d_ff[i] <= '0;
         end
      end else begin
         unique case (state_ff)
            ppghr_pkg::F_IDLE: begin
               // raw - 32768, doubled
               if (accept) x_ff <= SW'($signed({~in_raw_ir[15], in_raw_ir[14:0], 1'b0}));
            end
            ppghr_pkg::F_MULT: prod_ff <= $signed({1'b0, dc_alpha}) * dc_ff;
            ppghr_pkg::F_SUM:  m_ff <= m_sat;
            ppghr_pkg::F_Y: begin
               y_ff   <= ppghr_pkg::clip_one(ppghr_pkg::CLIP_W'(y_raw));
               dc_ff  <= m_ff;
               acc_ff <= '0;
               k_ff   <= 3'd0;
            end
            ppghr_pkg::F_MAC: begin
               acc_ff <= acc_in;
               k_ff   <= k_ff + 3'd1;
            end
            ppghr_pkg::F_PUSH: begin
               if (q_ready) begin
                  in_d_ff[2]  <= in_d_ff[1];
                  in_d_ff[1]  <= in_d_ff[0];
                  in_d_ff[0]  <= y_ff;
                  out_d_ff[2] <= out_d_ff[1];
                  out_d_ff[1] <= out_d_ff[0];
                  out_d_ff[0] <= filt;
               end
            end
            default: ;
         endcase
      end
   end
endmodule

>>> rtl/ppghr_queue.sv
// two-entry queue of filtered samples between front and back
module ppghr_queue (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  logic signed [ppghr_pkg::SAMP_W-1:0] in_data,
   output logic out_valid,
   input  logic out_ready,
   output logic signed [ppghr_pkg::SAMP_W-1:0] out_data
);
   logic signed [ppghr_pkg::SAMP_W-1:0] data_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = data_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) data_ff[wr_ptr_ff] <= in_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop) rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end
endmodule

>>> rtl/ppghr_back.sv
// back end: sample window, beat search, rate division and smoothing
module ppghr_back #(
   parameter int WINDOW     = ppghr_pkg::WINDOW_DEF,
   parameter int RATE_SCALE = ppghr_pkg::RATE_SCALE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [16:0] beat_threshold,
   input  logic [16:0] bpm_smoothing,
   input  logic        q_valid,
   output logic        q_ready,
   input  logic signed [ppghr_pkg::SAMP_W-1:0] q_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [17:0] rsp_filtered_sample,
   output logic [8:0]  rsp_beat_count,
   output logic [15:0] rsp_bpm_smoothed,
   output logic [7:0]  rsp_bpm_whole,
   output ppghr_pkg::back_status_type status
);
   localparam int SW    = ppghr_pkg::SAMP_W;
   localparam int IDX_W = $clog2(WINDOW);
   localparam int CNT_W = $clog2(WINDOW + 1);
   localparam int RS_W  = $clog2(RATE_SCALE + 1);
   localparam int NUM_W = IDX_W + RS_W + 8;
   localparam int DC_W  = $clog2(NUM_W);
   localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(WINDOW - 1);
   localparam logic [IDX_W-1:0] LAST_DIFF = IDX_W'(WINDOW - 2);

   ppghr_pkg::back_state_type state_ff, state_in;

   logic signed [SW-1:0] ring_ff [WINDOW];
   logic signed [SW-1:0] rdata_ff, prev_samp_ff, filt_ff;
   logic                 mem_we;
   logic [IDX_W-1:0]     mem_waddr;
   logic signed [SW-1:0] mem_wdata;

   logic [IDX_W-1:0] clr_ff, wp_ff, rd_addr_ff, s1_k_ff, s2_i_ff, first_ff, last_ff;
   logic [CNT_W-1:0] rd_cnt_ff;
   logic             s1_valid_ff, s2_valid_ff, issue;
   logic [35:0]      sq_ff;
   logic signed [18:0] d, prev_s_ff, s_val;
   logic [41:0]      sq100;
   logic [25:0]      t_rnd;
   logic [IDX_W-1:0] count_ff;
   logic             hit, walk_done, zero_rate;

   logic [NUM_W-1:0] quo_ff;
   logic [IDX_W-1:0] rem_ff, den_ff;
   logic [IDX_W:0]   r2;
   logic             ge;
   logic [DC_W-1:0]  div_cnt_ff;
   logic [15:0]      raw_ff, avg_ff;
   logic [16:0]      weight;
   logic [32:0]      p1_ff;
   logic [33:0]      blend;
   logic             load;

   assign q_ready   = (state_ff == ppghr_pkg::B_IDLE);
   assign issue     = (state_ff == ppghr_pkg::B_WALK) && (rd_cnt_ff < CNT_W'(WINDOW));
   assign walk_done = s2_valid_ff && (s2_i_ff == LAST_DIFF);
   assign zero_rate = (count_ff == '0) || (last_ff == first_ff);
   assign load      = (state_ff == ppghr_pkg::B_OUT) && (!rsp_valid || rsp_ready);

   assign status.clearing    = (state_ff == ppghr_pkg::B_CLEAR);
   assign status.div_start   = (state_ff == ppghr_pkg::B_DIVSET) && !zero_rate;
   assign status.den_nonzero = (last_ff != first_ff);

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = clr_ff;
      mem_wdata = '0;
      if (state_ff == ppghr_pkg::B_CLEAR) begin
         mem_we = 1'b1;
      end else if (q_valid && q_ready) begin
         mem_we    = 1'b1;
         mem_waddr = wp_ff;
         mem_wdata = q_data;
      end
   end

   // conditioned derivative and upward crossing test
   always_comb begin
      d     = 19'(rdata_ff) - 19'(prev_samp_ff);
      sq100 = (42'(sq_ff) << 6) + (42'(sq_ff) << 5) + (42'(sq_ff) << 2) + 42'd32768;
      t_rnd = sq100[41:16];
      if (t_rnd > 26'd131072) s_val = 19'sd65536;
      else s_val = 19'(t_rnd) - 19'sd65536;
      hit = s2_valid_ff && (s2_i_ff >= IDX_W'(2))
            && (prev_s_ff <= $signed({2'b00, beat_threshold}))
            && (s_val > $signed({2'b00, beat_threshold}));
   end

   always_comb begin
      r2     = {rem_ff, quo_ff[NUM_W-1]};
      ge     = (r2 >= {1'b0, den_ff});
      weight = (bpm_smoothing > 17'd65536) ? 17'd65536 : bpm_smoothing;
      blend  = 34'(17'd65536 - weight) * 34'(avg_ff) + 34'(p1_ff) + 34'd32768;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ppghr_pkg::B_CLEAR:  if (clr_ff == LAST_ADDR) state_in = ppghr_pkg::B_IDLE;
         ppghr_pkg::B_IDLE:   if (q_valid) state_in = ppghr_pkg::B_WALK;
         ppghr_pkg::B_WALK:   if (walk_done) state_in = ppghr_pkg::B_DIVSET;
         ppghr_pkg::B_DIVSET: state_in = zero_rate ? ppghr_pkg::B_BL1 : ppghr_pkg::B_DIV;
         ppghr_pkg::B_DIV:
            if (div_cnt_ff == DC_W'(NUM_W - 1)) state_in = ppghr_pkg::B_SAT;
         ppghr_pkg::B_SAT:    state_in = ppghr_pkg::B_BL1;
         ppghr_pkg::B_BL1:    state_in = ppghr_pkg::B_BL2;
         ppghr_pkg::B_BL2:    state_in = ppghr_pkg::B_OUT;
         ppghr_pkg::B_OUT:    if (load) state_in = ppghr_pkg::B_IDLE;
         default:             state_in = ppghr_pkg::B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ppghr_pkg::B_CLEAR;
      else state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) ring_ff[mem_waddr] <= mem_wdata;
      rdata_ff <= ring_ff[rd_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= '0;
         wp_ff       <= '0;
         avg_ff      <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         rsp_valid   <= 1'b0;
      end else begin
         s1_valid_ff <= issue;
         s1_k_ff     <= rd_cnt_ff[IDX_W-1:0];
         s2_valid_ff <= s1_valid_ff && (s1_k_ff != '0);
         if (state_ff == ppghr_pkg::B_CLEAR) clr_ff <= clr_ff + IDX_W'(1);
         if (q_valid && q_ready) begin
            filt_ff    <= q_data;
            rd_addr_ff <= wp_ff;
            rd_cnt_ff  <= '0;
            count_ff   <= '0;
            first_ff   <= '0;
            last_ff    <= '0;
         end
         if (issue) begin
            rd_cnt_ff  <= rd_cnt_ff + CNT_W'(1);
            rd_addr_ff <= (rd_addr_ff == LAST_ADDR) ? '0 : rd_addr_ff + IDX_W'(1);
         end
         if (s1_valid_ff) begin
            prev_samp_ff <= rdata_ff;
            sq_ff   <= (d > 19'sd0) ? 36'(d[17:0]) * 36'(d[17:0]) : '0;
            s2_i_ff <= s1_k_ff - IDX_W'(1);
         end
         if (s2_valid_ff) prev_s_ff <= s_val;
         if (hit) begin
            if (count_ff == '0) first_ff <= s2_i_ff - IDX_W'(1);
            last_ff  <= s2_i_ff - IDX_W'(1);
            count_ff <= count_ff + IDX_W'(1);
         end
         unique case (state_ff)
            ppghr_pkg::B_DIVSET: begin
               raw_ff     <= '0;
               quo_ff     <= NUM_W'(NUM_W'(count_ff) * NUM_W'(RATE_SCALE)) << 8;
               den_ff     <= last_ff - first_ff;
               rem_ff     <= '0;
               div_cnt_ff <= '0;
            end
            ppghr_pkg::B_DIV: begin
               rem_ff     <= ge ? IDX_W'(r2 - {1'b0, den_ff}) : IDX_W'(r2);
               quo_ff     <= {quo_ff[NUM_W-2:0], ge};
               div_cnt_ff <= div_cnt_ff + DC_W'(1);
            end
            ppghr_pkg::B_SAT:
               raw_ff <= (quo_ff > NUM_W'(ppghr_pkg::BPM_MAX)) ? ppghr_pkg::BPM_MAX
                                                              : quo_ff[15:0];
            ppghr_pkg::B_BL1: p1_ff <= 33'(weight) * 33'(raw_ff);
            ppghr_pkg::B_BL2: avg_ff <= blend[31:16];
            default: ;
         endcase
         if (load) begin
            rsp_valid           <= 1'b1;
            rsp_filtered_sample <= filt_ff;
            rsp_beat_count      <= 9'(count_ff);
            rsp_bpm_smoothed    <= avg_ff;
            rsp_bpm_whole       <= avg_ff[15:8];
            wp_ff <= (wp_ff == LAST_ADDR) ? '0 : wp_ff + IDX_W'(1);
         end else if (rsp_ready) begin
            rsp_valid <= 1'b0;
         end
      end
   end
endmodule

>>> rtl/ppg_filter_and_heart_rate_unit.sv
// top level of the ppg filter and heart rate unit
//  channel | direction | payload
//  req     | in        | raw_ir
//  rsp     | out       | filtered_sample, beat_count, bpm_smoothed, bpm_whole
//  csr     | in        | csr_we, csr_index, csr_wdata
// front end takes one sample at a time on one multiply-accumulate unit.
// back end handles one sample at a time: one read of the window ring per cycle,
// then a one-bit-per-cycle restoring divider, skipped when no rate is formed.
// after reset the ring is cleared; req.ready stays low while it is.
// a stalled response holds the back end; the two-entry queue lets the front go on.
`include "ppg_filter_and_heart_rate_unit_assert.svh"
module ppg_filter_and_heart_rate_unit #(
   parameter int WINDOW     = ppghr_pkg::WINDOW_DEF,
   parameter int RATE_SCALE = ppghr_pkg::RATE_SCALE_DEF
) (
   input  logic clock,
   input  logic reset,
   ppghr_req_if.sink   req,
   ppghr_rsp_if.source rsp,
   input  logic csr_we,
   input  logic [ppghr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ppghr_pkg::CSR_DATA_W-1:0] csr_wdata
);
   logic [15:0] dc_alpha_ff;
   logic [16:0] beat_threshold_ff, bpm_smoothing_ff;
   logic        fq_valid, fq_ready, qb_valid, qb_ready;
   logic signed [ppghr_pkg::SAMP_W-1:0] fq_data, qb_data;
   ppghr_pkg::back_status_type bk_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         dc_alpha_ff       <= ppghr_pkg::DC_ALPHA_RST;
         beat_threshold_ff <= ppghr_pkg::BEAT_THRESHOLD_RST;
         bpm_smoothing_ff  <= ppghr_pkg::BPM_SMOOTHING_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            ppghr_pkg::CSR_DC_ALPHA:       dc_alpha_ff <= csr_wdata[15:0];
            ppghr_pkg::CSR_BEAT_THRESHOLD: beat_threshold_ff <= csr_wdata;
            ppghr_pkg::CSR_BPM_SMOOTHING:  bpm_smoothing_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   ppghr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .dc_alpha  (dc_alpha_ff),
      .hold      (bk_status.clearing),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .in_raw_ir (req.raw_ir),
      .q_valid   (fq_valid),
      .q_ready   (fq_ready),
      .q_data    (fq_data)
   );

   ppghr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_data   (fq_data),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_data  (qb_data)
   );

   ppghr_back #(
      .WINDOW     (WINDOW),
      .RATE_SCALE (RATE_SCALE)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .beat_threshold      (beat_threshold_ff),
      .bpm_smoothing       (bpm_smoothing_ff),
      .q_valid             (qb_valid),
      .q_ready             (qb_ready),
      .q_data              (qb_data),
      .rsp_valid           (rsp.valid),
      .rsp_ready           (rsp.ready),
      .rsp_filtered_sample (rsp.filtered_sample),
      .rsp_beat_count      (rsp.beat_count),
      .rsp_bpm_smoothed    (rsp.bpm_smoothed),
      .rsp_bpm_whole       (rsp.bpm_whole),
      .status              (bk_status)
   );

   `PPGHR_ASSERT_ALWAYS(a_no_req_while_clear, clock, reset, !(bk_status.clearing && req.ready))
   `PPGHR_ASSERT_NEXT(a_queue_fill, clock, reset, fq_valid && fq_ready, qb_valid)
   `PPGHR_ASSERT_ALWAYS(a_div_den, clock, reset, !bk_status.div_start || bk_status.den_nonzero)
endmodule
